/* rtl/core/mbe_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helpers of the mandelbrot escape-time engine
package mbe_pkg;

   // default build values
   localparam int PIXEL_BITS_DEF = 12;
   localparam int ITER_BITS_DEF  = 16;
   localparam int FRAC_BITS_DEF  = 28;

   localparam int WORD_W = 32;
   localparam int PROD_W = 64;
   // wide enough for every pre-saturation sum in the datapath
   localparam int SAT_W  = 66;

   // register file
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOP_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;

   localparam logic signed [WORD_W-1:0] LEFT_X_RST = -32'sd199984415;
   localparam logic signed [WORD_W-1:0] TOP_Y_RST  = 32'sd40265318;
   localparam logic signed [WORD_W-1:0] STEP_X_RST = 32'sd524;
   localparam logic signed [WORD_W-1:0] STEP_Y_RST = 32'sd839;
   localparam int ITER_LIMIT_RST = 20000;

   // color map: v = min(floor(n*64/125), 256)
   localparam int COLOR_SAT_ITER = 500;
   localparam logic [15:0] COLOR_RECIP = 16'd33555;  // ceil(2^22/125), i.e. 64/125 scaled by 2^16
   localparam int COLOR_RECIP_SHIFT = 16;
   localparam logic [8:0] COLOR_V_MAX = 9'd256;
   localparam logic [WORD_W-1:0] COLOR_BASE = 32'd255;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COORD,
      ST_MUL,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic coord;
      logic mul;
      logic update;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic escape;
      logic last_iter;
      logic zero_limit;
   } status_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] left_x;
      logic signed [WORD_W-1:0] top_y;
      logic signed [WORD_W-1:0] step_x;
      logic signed [WORD_W-1:0] step_y;
   } cfg_type;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'(32'sh7fffffff);
      lo = SAT_W'(-33'sh80000000);
      if (v > hi) begin
         return 32'sh7fffffff;
      end else if (v < lo) begin
         return 32'sh80000000;
      end else begin
         return v[WORD_W-1:0];
      end
   endfunction

endpackage

/* rtl/core/mbe_csr.sv */
`timescale 1ns / 1ps
// apb register file holding the view window and the iteration limit
module mbe_csr import mbe_pkg::*; #(
   parameter int ITER_BITS = ITER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [WORD_W-1:0]     pwdata,
   output logic [WORD_W-1:0]     prdata,
   output logic                  pready,
   output cfg_type               cfg,
   output logic [ITER_BITS-1:0]  iter_limit
);

   logic signed [WORD_W-1:0] left_x_ff, top_y_ff, step_x_ff, step_y_ff;
   logic [ITER_BITS-1:0]     iter_limit_ff;
   logic                     wr_en;
   logic [CSR_IDX_W-1:0]     idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         left_x_ff     <= LEFT_X_RST;
         top_y_ff      <= TOP_Y_RST;
         step_x_ff     <= STEP_X_RST;
         step_y_ff     <= STEP_Y_RST;
         iter_limit_ff <= ITER_BITS'(ITER_LIMIT_RST);
      end else if (wr_en) begin
         case (idx)
            REG_LEFT_X:     left_x_ff     <= pwdata;
            REG_TOP_Y:      top_y_ff      <= pwdata;
            REG_STEP_X:     step_x_ff     <= pwdata;
            REG_STEP_Y:     step_y_ff     <= pwdata;
            REG_ITER_LIMIT: iter_limit_ff <= pwdata[ITER_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_LEFT_X:     prdata = left_x_ff;
         REG_TOP_Y:      prdata = top_y_ff;
         REG_STEP_X:     prdata = step_x_ff;
         REG_STEP_Y:     prdata = step_y_ff;
         REG_ITER_LIMIT: prdata = WORD_W'(iter_limit_ff);
         default:        prdata = '0;
      endcase
   end

   assign cfg.left_x = left_x_ff;
   assign cfg.top_y  = top_y_ff;
   assign cfg.step_x = step_x_ff;
   assign cfg.step_y = step_y_ff;
   assign iter_limit = iter_limit_ff;

endmodule

/* rtl/core/mbe_ctrl.sv */
`timescale 1ns / 1ps
// sequencer: coordinate setup, multiply/update iteration loop, result
module mbe_ctrl import mbe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_COORD;
         end
         ST_COORD: begin
            state_in = status.zero_limit ? ST_FINISH : ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // escape leaves the count as is; otherwise stop once the limit is reached
            if (status.escape || status.last_iter) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_COORD:  cmd.coord  = 1'b1;
         ST_MUL:    cmd.mul    = 1'b1;
         ST_UPDATE: cmd.update = 1'b1;
         ST_FINISH: cmd.finish = 1'b1;
         default:   busy       = 1'b0;
      endcase
   end

endmodule

/* rtl/core/mbe_dp.sv */
`timescale 1ns / 1ps
// datapath: point setup, fixed-point z*z+c iterate, escape test, color map
module mbe_dp import mbe_pkg::*; #(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int ITER_BITS  = ITER_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  cfg_type               cfg,
   input  logic [ITER_BITS-1:0]  iter_limit,
   input  logic [PIXEL_BITS-1:0] req_pixel_col,
   input  logic [PIXEL_BITS-1:0] req_pixel_row,
   output status_type            status,
   output logic                  rsp_valid,
   output logic [ITER_BITS-1:0]  rsp_iterations,
   output logic [WORD_W-1:0]     rsp_color
);

   localparam int CM_W = PIXEL_BITS + WORD_W + 1;
   localparam logic signed [PROD_W:0] FOUR = (PROD_W+1)'(4) <<< FRAC_BITS;

   logic signed [CM_W-1:0]   mx_ff, my_ff;
   logic signed [WORD_W-1:0] cx_ff, cy_ff, x_ff, y_ff;
   logic signed [PROD_W-1:0] pxx_ff, pyy_ff, pxy_ff;
   logic [ITER_BITS-1:0]     it_ff;
   logic                     rsp_valid_ff;
   logic [ITER_BITS-1:0]     rsp_iter_ff;
   logic [WORD_W-1:0]        rsp_color_ff;

   logic signed [PROD_W-1:0] x2, y2, twoxy;
   logic signed [PROD_W:0]   mag;
   logic signed [SAT_W-1:0]  nx, ny, cx_sum, cy_sum;
   logic [ITER_BITS-1:0]     it_next;
   logic [8:0]               it9, v9;
   logic [24:0]              recip_prod;
   logic [WORD_W-1:0]        vw, color;

   // floor shifts of the exact products
   assign x2     = pxx_ff >>> FRAC_BITS;
   assign y2     = pyy_ff >>> FRAC_BITS;
   assign twoxy  = pxy_ff >>> (FRAC_BITS - 1);
   assign mag    = (PROD_W+1)'(x2) + (PROD_W+1)'(y2);
   assign nx     = SAT_W'(x2) - SAT_W'(y2) + SAT_W'(cx_ff);
   assign ny     = SAT_W'(twoxy) + SAT_W'(cy_ff);
   assign cx_sum = SAT_W'(cfg.left_x) + SAT_W'(mx_ff);
   assign cy_sum = SAT_W'(cfg.top_y) - SAT_W'(my_ff);
   assign it_next = it_ff + 1'b1;

   assign status.escape     = mag > FOUR;
   assign status.last_iter  = it_next == iter_limit;
   assign status.zero_limit = iter_limit == '0;

   // floor(n*64/125) by reciprocal, exact below the clamp point
   assign it9        = 9'(it_ff);
   assign recip_prod = 25'(it9) * 25'(COLOR_RECIP);
   assign v9 = (WORD_W'(it_ff) >= WORD_W'(COLOR_SAT_ITER)) ? COLOR_V_MAX
                                                             : 9'(recip_prod >> COLOR_RECIP_SHIFT);
   assign vw    = WORD_W'(v9);
   assign color = (vw << 16) | ((COLOR_BASE - vw) << 8);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mx_ff <= CM_W'($signed({1'b0, req_pixel_col})) * CM_W'(cfg.step_x);
         my_ff <= CM_W'($signed({1'b0, req_pixel_row})) * CM_W'(cfg.step_y);
      end
      if (cmd.coord) begin
         cx_ff <= sat_word(cx_sum);
         cy_ff <= sat_word(cy_sum);
         x_ff  <= '0;
         y_ff  <= '0;
         it_ff <= '0;
      end
      if (cmd.mul) begin
         pxx_ff <= PROD_W'(x_ff) * PROD_W'(x_ff);
         pyy_ff <= PROD_W'(y_ff) * PROD_W'(y_ff);
         pxy_ff <= PROD_W'(x_ff) * PROD_W'(y_ff);
      end
      if (cmd.update && !status.escape) begin
         x_ff  <= sat_word(nx);
         y_ff  <= sat_word(ny);
         it_ff <= it_next;
      end
      if (cmd.finish) begin
         rsp_iter_ff  <= it_ff;
         rsp_color_ff <= color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iterations = rsp_iter_ff;
   assign rsp_color      = rsp_color_ff;

endmodule

/* rtl/core/mandelbrot_escape_time_pixel.sv */
`timescale 1ns / 1ps
// top level of the mandelbrot escape-time pixel engine
//
//   channel   ports                                  transaction
//   request   start, busy, req_pixel_*               start high while busy low
//   result    rsp_valid, rsp_iterations, rsp_color   rsp_valid high for one cycle
//   config    psel/penable/pwrite/paddr/pwdata       apb write, pready tied high
//
// from start, one pixel runs through the coordinate state, then multiply and update
// states in turn, one pair per z*z+c step, until escape or the limit, then the finish
// state; the three 32x32 multipliers work in the multiply state, the update adds/saturates.
// busy drops in the cycle rsp_valid shows the result; a new start is taken then.
// reset is synchronous and loads the default view; results cannot be stalled.
module mandelbrot_escape_time_pixel import mbe_pkg::*; #(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int ITER_BITS  = ITER_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [PIXEL_BITS-1:0] req_pixel_col,
   input  logic [PIXEL_BITS-1:0] req_pixel_row,
   output logic                  rsp_valid,
   output logic [ITER_BITS-1:0]  rsp_iterations,
   output logic [WORD_W-1:0]     rsp_color,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [WORD_W-1:0]     pwdata,
   output logic [WORD_W-1:0]     prdata,
   output logic                  pready
);

   cfg_type              cfg;
   logic [ITER_BITS-1:0] iter_limit;
   cmd_type              cmd;
   status_type           status;

   mbe_csr #(
      .ITER_BITS (ITER_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cfg        (cfg),
      .iter_limit (iter_limit)
   );

   mbe_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   mbe_dp #(
      .PIXEL_BITS (PIXEL_BITS),
      .ITER_BITS  (ITER_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg),
      .iter_limit     (iter_limit),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_iterations (rsp_iterations),
      .rsp_color      (rsp_color)
   );

   // a result only follows a cycle of work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a transaction in flight");

   // one strobe per transaction
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_iter_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_iterations <= iter_limit))
      else $error("iteration count beyond the limit");

endmodule
